// ===== rtl/saes_pkg.sv =====
// Package with the S-boxes, GF(16) arithmetic and round functions of the cipher.
package saes_pkg;

    typedef logic [3:0]  nibble_t;
    typedef logic [7:0]  byte_t;
    typedef logic [15:0] block_t;

    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    localparam byte_t RCON_1 = 8'h80;
    localparam byte_t RCON_2 = 8'h30;

    localparam nibble_t MIX_DIAG_FWD = 4'h1;
    localparam nibble_t MIX_OFF_FWD  = 4'h4;
    localparam nibble_t MIX_DIAG_INV = 4'h9;
    localparam nibble_t MIX_OFF_INV  = 4'h2;

    localparam logic [4:0] GF_POLY = 5'h13;

    typedef struct packed {
        block_t rk0;
        block_t rk1;
        block_t rk2;
    } round_keys_t;

    function automatic nibble_t sbox_fwd(input nibble_t n);
        nibble_t r;
        case (n)
            4'h0: r = 4'h9;
            4'h1: r = 4'h4;
            4'h2: r = 4'hA;
            4'h3: r = 4'hB;
            4'h4: r = 4'hD;
            4'h5: r = 4'h1;
            4'h6: r = 4'h8;
            4'h7: r = 4'h5;
            4'h8: r = 4'h6;
            4'h9: r = 4'h2;
            4'hA: r = 4'h0;
            4'hB: r = 4'h3;
            4'hC: r = 4'hC;
            4'hD: r = 4'hE;
            4'hE: r = 4'hF;
            4'hF: r = 4'h7;
            default: r = 4'h0;
        endcase
        return r;
    endfunction

    function automatic nibble_t inv_sbox(input nibble_t n);
        nibble_t r;
        case (n)
            4'h0: r = 4'hA;
            4'h1: r = 4'h5;
            4'h2: r = 4'h9;
            4'h3: r = 4'hB;
            4'h4: r = 4'h1;
            4'h5: r = 4'h7;
            4'h6: r = 4'h8;
            4'h7: r = 4'hF;
            4'h8: r = 4'h6;
            4'h9: r = 4'h0;
            4'hA: r = 4'h2;
            4'hB: r = 4'h3;
            4'hC: r = 4'hC;
            4'hD: r = 4'h4;
            4'hE: r = 4'hD;
            4'hF: r = 4'hE;
            default: r = 4'h0;
        endcase
        return r;
    endfunction

    function automatic block_t sub_word_fwd(input block_t w);
        return {sbox_fwd(w[15:12]), sbox_fwd(w[11:8]), sbox_fwd(w[7:4]), sbox_fwd(w[3:0])};
    endfunction

    function automatic block_t sub_word_inv(input block_t w);
        return {inv_sbox(w[15:12]), inv_sbox(w[11:8]), inv_sbox(w[7:4]), inv_sbox(w[3:0])};
    endfunction

    // Swaps the second and the fourth nibble.
    function automatic block_t shift_rows(input block_t w);
        return {w[15:12], w[3:0], w[7:4], w[11:8]};
    endfunction

    function automatic nibble_t gf16_mul(input nibble_t a, input nibble_t b);
        logic [4:0] aa;
        nibble_t    acc;
        aa  = {1'b0, a};
        acc = '0;
        for (int i = 0; i < 4; i++)
        begin
            if (b[i])
            begin
                acc = acc ^ aa[3:0];
            end
            aa = {aa[3:0], 1'b0};
            if (aa[4])
            begin
                aa = aa ^ GF_POLY;
            end
        end
        return acc;
    endfunction

    function automatic block_t mix_cols(input block_t w, input nibble_t diag,
                                        input nibble_t off);
        nibble_t m0;
        nibble_t m1;
        nibble_t m2;
        nibble_t m3;
        m0 = gf16_mul(diag, w[15:12]) ^ gf16_mul(off, w[11:8]);
        m1 = gf16_mul(off, w[15:12]) ^ gf16_mul(diag, w[11:8]);
        m2 = gf16_mul(diag, w[7:4]) ^ gf16_mul(off, w[3:0]);
        m3 = gf16_mul(off, w[7:4]) ^ gf16_mul(diag, w[3:0]);
        return {m0, m1, m2, m3};
    endfunction

    function automatic byte_t sub_rot_byte(input byte_t v);
        return {sbox_fwd(v[3:0]), sbox_fwd(v[7:4])};
    endfunction

    function automatic round_keys_t expand_key(input block_t key);
        round_keys_t rk;
        byte_t       w0;
        byte_t       w1;
        byte_t       w2;
        byte_t       w3;
        byte_t       w4;
        byte_t       w5;
        w0 = key[15:8];
        w1 = key[7:0];
        w2 = w0 ^ RCON_1 ^ sub_rot_byte(w1);
        w3 = w2 ^ w1;
        w4 = w2 ^ RCON_2 ^ sub_rot_byte(w3);
        w5 = w4 ^ w3;
        rk.rk0 = key;
        rk.rk1 = {w2, w3};
        rk.rk2 = {w4, w5};
        return rk;
    endfunction

endpackage

// ===== rtl/simplified_aes_block_cipher.sv =====
// Three-stage pipelined S-AES encrypt/decrypt core with a key register.
// A request passes the three pipeline registers s1_reg, s2_reg, s3_reg to the result.
// Throughput: one request per cycle unless a valid result is stalled.
// A stalled valid result holds the whole pipeline, and the input stalls only then.
// Reset clears the key to zero and all pipeline valid bits.
module simplified_aes_block_cipher
    import saes_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cipher_key_we,
    input  logic [15:0] cipher_key,
    input  logic        data_valid,
    output logic        data_stall,
    input  logic        op,
    input  logic [15:0] data_block,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [15:0] result_block
);

    block_t      key_reg;
    round_keys_t rk;
    logic        advance;

    logic        v1_reg, v2_reg, v3_reg;
    logic        op1_reg, op2_reg;
    block_t      s1_reg, s2_reg, s3_reg;
    block_t      s1_next, s2_next, s3_next;

    assign rk      = expand_key(key_reg);
    assign advance = !(v3_reg && result_stall);

    assign data_stall   = !advance;
    assign result_valid = v3_reg;
    assign result_block = s3_reg;

    always_comb
    begin
        if (op == OP_ENCRYPT)
        begin
            s1_next = shift_rows(sub_word_fwd(data_block ^ rk.rk0));
        end
        else
        begin
            s1_next = sub_word_inv(shift_rows(data_block ^ rk.rk2)) ^ rk.rk1;
        end

        if (op1_reg == OP_ENCRYPT)
        begin
            s2_next = mix_cols(s1_reg, MIX_DIAG_FWD, MIX_OFF_FWD) ^ rk.rk1;
        end
        else
        begin
            s2_next = mix_cols(s1_reg, MIX_DIAG_INV, MIX_OFF_INV);
        end

        if (op2_reg == OP_ENCRYPT)
        begin
            s3_next = shift_rows(sub_word_fwd(s2_reg)) ^ rk.rk2;
        end
        else
        begin
            s3_next = sub_word_inv(shift_rows(s2_reg)) ^ rk.rk0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
        end
        else
        begin
            if (cipher_key_we)
            begin
                key_reg <= cipher_key;
            end
            if (advance)
            begin
                v1_reg <= data_valid;
                v2_reg <= v1_reg;
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            op1_reg <= op;
            s1_reg  <= s1_next;
            op2_reg <= op1_reg;
            s2_reg  <= s2_next;
            s3_reg  <= s3_next;
        end
    end

endmodule

// ===== rtl/saes_checker.sv =====
// Port-level checker for the S-AES core and its bind to the top level.
module saes_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        data_valid,
    input logic        data_stall,
    input logic        result_valid,
    input logic        result_stall,
    input logic [15:0] result_block
);

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("Result valid dropped while stalled.");

    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(result_block))
        else $error("Result changed while stalled.");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        data_stall |-> result_valid && result_stall)
        else $error("Input stalled without a stalled result.");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (data_valid && !data_stall) ##1 !result_stall ##1 !result_stall |=> result_valid)
        else $error("Accepted request did not reach the output in three cycles.");

endmodule

bind simplified_aes_block_cipher saes_checker u_saes_checker (.*);
